FILE: rtl/fec_pkg.sv
// Package with the shared constants of the feedback comb echo block.
package fec_pkg;

    // Default ring depth in interleaved samples.
    localparam int RING_DEPTH_DEF = 131072;

    // Sample width of the audio path and of a ring entry.
    localparam int SAMPLE_BITS = 16;

    // Configuration port widths.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 18;
    localparam int LEN_BITS       = 18;
    localparam int GAIN_BITS      = 16;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_RING_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ECHO_GAIN    = 2'd2;

    // Register values after reset.
    localparam logic [LEN_BITS-1:0]  RING_LENGTH_RST  = 18'd131072;
    localparam logic [LEN_BITS-1:0]  DELAY_LENGTH_RST = 18'd19200;
    localparam logic [GAIN_BITS-1:0] ECHO_GAIN_RST    = 16'd13107;

endpackage

FILE: rtl/feedback_echo_comb.sv
// Feedback comb echo: ring memory, read stage and multiply-accumulate write-back.
//
//  Channel | Signals                          | Direction | Transaction
//  --------+----------------------------------+-----------+------------------------------
//  cfg     | cfg_write, cfg_index, cfg_data   | in        | one register write per cycle
//  in      | in_valid, in_ready, sample_in    | in        | one interleaved sample
//  out     | out_valid, out_ready, sample_out | out       | one echoed, saturated sample
//
// One sample is taken per cycle while in_ready is high. A transaction reads the ring in
// the cycle it is taken; the compute stage then multiplies, saturates, writes back and
// loads the output register. The single ring port pair (one read, one write per cycle)
// sets that rate. Reset and every write to a known register empty the ring at once through
// a fill count, so no clearing pass is needed. When out is stalled, the compute stage
// holds and in_ready drops only once both the stage and the output are full.
module feedback_echo_comb #(
    parameter int RING_DEPTH = fec_pkg::RING_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [fec_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [fec_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [fec_pkg::SAMPLE_BITS-1:0] sample_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fec_pkg::SAMPLE_BITS-1:0] sample_out
);

    localparam int SB = fec_pkg::SAMPLE_BITS;
    localparam int AW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(RING_DEPTH + 1);
    localparam int CW = (LW > fec_pkg::LEN_BITS) ? LW : fec_pkg::LEN_BITS;
    localparam int PW = SB + fec_pkg::GAIN_BITS + 1;
    localparam int EW = PW - fec_pkg::GAIN_BITS + 1;
    localparam int XW = EW + 1;

    localparam logic [CW-1:0] DEPTH_CW = CW'(RING_DEPTH);
    localparam logic [CW-1:0] ONE_CW   = CW'(1);

    localparam logic signed [PW:0] ROUND_BIAS = (PW + 1)'(1 << (fec_pkg::GAIN_BITS - 1));
    localparam logic signed [XW-1:0] SMAX = XW'((1 << (SB - 1)) - 1);
    localparam logic signed [XW-1:0] SMIN = -SMAX - XW'(1);

    // Echo source selection codes for the compute stage.
    localparam logic [1:0] SRC_ZERO = 2'd0;
    localparam logic [1:0] SRC_MEM  = 2'd1;
    localparam logic [1:0] SRC_FWD  = 2'd2;

    // Configuration registers.
    logic [fec_pkg::LEN_BITS-1:0]  ring_length_reg;
    logic [fec_pkg::LEN_BITS-1:0]  delay_length_reg;
    logic [fec_pkg::GAIN_BITS-1:0] echo_gain_reg;
    logic                          cfg_hit;

    // Ring position and fill count.
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic [LW-1:0] fill_reg;
    logic [LW-1:0] fill_next;

    // Effective lengths.
    logic [CW-1:0] ring_cw;
    logic [CW-1:0] delay_cw;
    logic [CW-1:0] eff_len_cw;
    logic [CW-1:0] eff_delay_cw;
    logic [LW-1:0] eff_len;
    logic [LW-1:0] eff_delay;

    // Read address generation.
    logic [LW:0]   rd_diff;
    logic [LW:0]   rd_wide;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] pos_inc;
    logic          entry_written;

    // Handshake and stage registers.
    logic          accept;
    logic          s1_advance;
    logic          s1_valid_reg;
    logic [SB-1:0] s1_sample_reg;
    logic [AW-1:0] s1_pos_reg;
    logic [1:0]    s1_src_reg;
    logic [1:0]    src_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [SB-1:0] out_sample_reg;
    logic [SB-1:0] last_sum_reg;

    // Ring memory and its read register.
    logic [SB-1:0] ring_mem [RING_DEPTH];
    logic [SB-1:0] mem_rdata_reg;

    // Arithmetic of the compute stage.
    logic signed [SB-1:0]   echo_src;
    logic signed [PW-1:0]   product;
    logic signed [PW:0]     rounded;
    logic signed [EW-1:0]   echo;
    logic signed [XW-1:0]   sum;
    logic [SB-1:0]          sat_sum;

    // A write to a known register clears the ring.
    assign cfg_hit = cfg_write && ((cfg_index == fec_pkg::REG_RING_LENGTH)
                                || (cfg_index == fec_pkg::REG_DELAY_LENGTH)
                                || (cfg_index == fec_pkg::REG_ECHO_GAIN));

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_length_reg  <= fec_pkg::RING_LENGTH_RST;
            delay_length_reg <= fec_pkg::DELAY_LENGTH_RST;
            echo_gain_reg    <= fec_pkg::ECHO_GAIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fec_pkg::REG_RING_LENGTH:  ring_length_reg  <= cfg_data;
                fec_pkg::REG_DELAY_LENGTH: delay_length_reg <= cfg_data;
                fec_pkg::REG_ECHO_GAIN:    echo_gain_reg    <= cfg_data[fec_pkg::GAIN_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    // Clamp the ring length to the memory and the delay to the ring.
    always_comb
    begin
        ring_cw  = CW'(ring_length_reg);
        delay_cw = CW'(delay_length_reg);
        if (ring_cw == '0)
            eff_len_cw = ONE_CW;
        else if (ring_cw > DEPTH_CW)
            eff_len_cw = DEPTH_CW;
        else
            eff_len_cw = ring_cw;
        if (delay_cw == '0)
            eff_delay_cw = ONE_CW;
        else if (delay_cw > eff_len_cw)
            eff_delay_cw = eff_len_cw;
        else
            eff_delay_cw = delay_cw;
    end

    assign eff_len   = eff_len_cw[LW-1:0];
    assign eff_delay = eff_delay_cw[LW-1:0];

    // Read address is the write position minus the delay, modulo the ring length.
    always_comb
    begin
        rd_diff = (LW + 1)'(pos_reg) - (LW + 1)'(eff_delay);
        if (rd_diff[LW])
            rd_wide = rd_diff + (LW + 1)'(eff_len);
        else
            rd_wide = rd_diff;
    end

    assign rd_addr = rd_wide[AW-1:0];

    // Entries are written in order from zero, so the fill count marks which hold data.
    assign entry_written = (LW'(rd_addr) < fill_reg);

    // Position advance and fill count.
    assign pos_inc   = LW'(pos_reg) + LW'(1);
    assign pos_next  = (pos_inc == eff_len) ? '0 : pos_inc[AW-1:0];
    assign fill_next = (fill_reg == eff_len) ? fill_reg : fill_reg + LW'(1);

    // Handshake: the compute stage moves on whenever the output register can take it.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;

    // The transaction in the compute stage writes this edge; a read of that entry
    // takes the value being written instead of the stale memory word.
    always_comb
    begin
        if (s1_valid_reg && (s1_pos_reg == rd_addr))
            src_next = SRC_FWD;
        else if (entry_written)
            src_next = SRC_MEM;
        else
            src_next = SRC_ZERO;
    end

    // Position, fill count and read stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_src_reg   <= SRC_ZERO;
        end
        else if (cfg_hit)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg    <= pos_next;
                fill_reg   <= fill_next;
                s1_src_reg <= src_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_in;
            s1_pos_reg    <= pos_reg;
        end
    end

    // Ring memory: write-back from the compute stage, registered read on accept.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
            ring_mem[s1_pos_reg] <= sat_sum;
        if (accept)
            mem_rdata_reg <= ring_mem[rd_addr];
    end

    // Compute stage: scale the echo, round, add the input and saturate.
    always_comb
    begin
        case (s1_src_reg)
            SRC_MEM:  echo_src = $signed(mem_rdata_reg);
            SRC_FWD:  echo_src = $signed(last_sum_reg);
            default:  echo_src = '0;
        endcase
        product = echo_src * $signed({1'b0, echo_gain_reg});
        rounded = (PW + 1)'(product) + ROUND_BIAS;
        echo    = $signed(rounded[PW:fec_pkg::GAIN_BITS]);
        sum     = XW'($signed(s1_sample_reg)) + XW'(echo);
        if (sum > SMAX)
            sat_sum = SMAX[SB-1:0];
        else if (sum < SMIN)
            sat_sum = SMIN[SB-1:0];
        else
            sat_sum = sum[SB-1:0];
    end

    // Output register valid.
    always_comb
    begin
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Output sample and the forwarding copy of the last written value.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_sample_reg <= sat_sum;
            last_sum_reg   <= sat_sum;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = $signed(out_sample_reg);

endmodule

FILE: tb/feedback_echo_comb_test.sv
// Self-checking testbench for the feedback comb echo block with a built-in echo predictor.
module feedback_echo_comb_test;

    // Index that maps to no register; a write to it must leave everything untouched.
    localparam logic [fec_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam int RING_MAX = fec_pkg::RING_DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC} sink_mode_t;
    typedef logic signed [fec_pkg::SAMPLE_BITS-1:0] sample_t;
    typedef logic [fec_pkg::CFG_DATA_BITS-1:0] cfg_word_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_write;
    logic [fec_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    cfg_word_t                          cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    sample_t                            sample_in;
    logic                               out_valid;
    logic                               out_ready;
    sample_t                            sample_out;

    // Predictor state: register copies, the stored taps and the write pointer.
    logic [fec_pkg::LEN_BITS-1:0]  model_ring_len;
    logic [fec_pkg::LEN_BITS-1:0]  model_delay;
    logic [fec_pkg::GAIN_BITS-1:0] model_gain;
    sample_t                       model_taps [int];
    int unsigned                   model_wr_pos;

    sample_t     pending_samples [$];
    sample_t     echo_expected [$];
    int          fault_count;
    int          gap_left;
    int          burst_left;
    bit          source_bursty;
    sink_mode_t  sink_mode;
    bit          hold_off_go;
    int          hold_off_left;
    int unsigned sink_tick;

    feedback_echo_comb u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mirror a register write; a valid index clears the taps and the write pointer.
    function automatic void apply_register(logic [fec_pkg::CFG_INDEX_BITS-1:0] idx,
                                           cfg_word_t data);
        case (idx)
            fec_pkg::REG_RING_LENGTH:  model_ring_len = data;
            fec_pkg::REG_DELAY_LENGTH: model_delay = data;
            fec_pkg::REG_ECHO_GAIN:    model_gain = data[fec_pkg::GAIN_BITS-1:0];
            default:                   return;
        endcase
        model_taps.delete();
        model_wr_pos = 0;
    endfunction

    // Compute one output sample and update the stored taps.
    function automatic sample_t echo_predict(sample_t x);
        int unsigned       len;
        int unsigned       dly;
        int unsigned       rd;
        sample_t           tap;
        logic signed [33:0] prod;
        logic signed [33:0] total;
        sample_t           result;
        len = model_ring_len;
        if (len < 1) len = 1;
        if (len > RING_MAX) len = RING_MAX;
        dly = model_delay;
        if (dly < 1) dly = 1;
        if (dly > len) dly = len;
        model_wr_pos = model_wr_pos % len;
        rd = (model_wr_pos + len - dly) % len;
        tap = model_taps.exists(rd) ? model_taps[rd] : '0;
        // Q1.15 times Q0.16, rounded half up back to Q1.15.
        prod = $signed(tap) * $signed({1'b0, model_gain});
        prod = prod + 34'sd32768;
        total = x + (prod >>> 16);
        if (total > 34'sd32767)
            result = 16'sh7FFF;
        else if (total < -34'sd32768)
            result = 16'sh8000;
        else
            result = total[fec_pkg::SAMPLE_BITS-1:0];
        model_taps[model_wr_pos] = result;
        model_wr_pos = (model_wr_pos + 1) % len;
        return result;
    endfunction

    // Record a failure; only the first ten are printed.
    task automatic report_fault(bit unexpected, sample_t want, sample_t got);
        fault_count++;
        if (fault_count <= 10)
        begin
            if (unexpected)
                $display("sample_out %0d arrived with no transaction pending", got);
            else
                $display("sample_out mismatch: expected %0d, got %0d", want, got);
        end
    endtask

    // Input driver: bursts of transactions from the pending queue with random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                echo_expected.push_back(echo_predict(sample_in));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    in_valid  <= 1'b1;
                    sample_in <= pending_samples.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = source_bursty ? $urandom_range(1, 6) : 0;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output receiver: stall pattern per phase, plus an occasional long hold-off.
    always @(posedge clk)
    begin
        sink_tick++;
        if (hold_off_go)
        begin
            hold_off_left = HOLD_OFF_CYCLES;
            hold_off_go = 1'b0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_OPEN:   out_ready <= 1'b1;
                SINK_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
                default:     out_ready <= ((sink_tick % 8) < 5);
            endcase
        end
    end

    // Output monitor: compare each transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (echo_expected.size() == 0)
                report_fault(1'b1, '0, sample_out);
            else if (sample_out !== echo_expected[0])
                report_fault(1'b0, echo_expected.pop_front(), sample_out);
            else
                void'(echo_expected.pop_front());
        end
    end

    // Write one register at the next rising edge and mirror it in the predictor.
    task automatic cfg_put(logic [fec_pkg::CFG_INDEX_BITS-1:0] idx, cfg_word_t data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_register(idx, data);
    endtask

    // Write all three registers back to back.
    task automatic configure(int ring, int dly, int gain);
        cfg_put(fec_pkg::REG_RING_LENGTH, cfg_word_t'(ring));
        cfg_put(fec_pkg::REG_DELAY_LENGTH, cfg_word_t'(dly));
        cfg_put(fec_pkg::REG_ECHO_GAIN, cfg_word_t'(gain));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Wait until every queued sample is sent and every result has arrived.
    task automatic drain();
        @(negedge clk);
        while (pending_samples.size() > 0 || echo_expected.size() > 0 || in_valid)
            @(negedge clk);
    endtask

    // Random sample, biased toward full scale and near zero.
    function automatic sample_t pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return sample_t'($urandom_range(0, 65535));
        else if (sel < 8)
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        else
            return $signed(16'($urandom_range(0, 64))) - 16'sd32;
    endfunction

    // Queue a batch of random samples under a random traffic pattern and wait for it.
    task automatic send_batch(int count);
        @(negedge clk);
        source_bursty = $urandom_range(0, 2) != 0;
        sink_mode = sink_mode_t'($urandom_range(0, 2));
        for (int i = 0; i < count; i++)
            pending_samples.push_back(pick_sample());
        if ($urandom_range(0, 3) == 0)
            hold_off_go = 1'b1;
        drain();
    endtask

    // Stimulus sequence.
    initial
    begin
        int ring;
        int dly;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        sample_in     = '0;
        out_ready     = 1'b0;
        fault_count   = 0;
        gap_left      = 0;
        burst_left    = 1;
        source_bursty = 1'b0;
        sink_mode     = SINK_OPEN;
        hold_off_go   = 1'b0;
        hold_off_left = 0;
        sink_tick     = 0;
        model_ring_len = fec_pkg::RING_LENGTH_RST;
        model_delay    = fec_pkg::DELAY_LENGTH_RST;
        model_gain     = fec_pkg::ECHO_GAIN_RST;
        model_wr_pos   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: the echo tap is still empty, so samples pass straight through.
        @(negedge clk);
        pending_samples = {16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh5555, 16'shAAAA};
        drain();

        // Delay of one with full gain: each sample feeds back the one just written.
        configure(3, 1, 65535);
        @(negedge clk);
        pending_samples = {16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0001, 16'sh0000};
        drain();

        // Delay equal to the ring length: the entry is read before it is overwritten.
        configure(4, 4, 32768);
        @(negedge clk);
        pending_samples = {16'sh4000, 16'shC000, 16'sh0001, 16'shFFFF, 16'sh7FFF, 16'sh8000,
                           16'sh0003};
        drain();

        // Zero ring length and zero delay both act as one.
        configure(0, 0, 40000);
        @(negedge clk);
        pending_samples = {16'sh1000, 16'sh1000, 16'shF000, 16'sh0000};
        drain();

        // Ring length beyond the memory depth, short delay, with a long output stall.
        configure(18'h3FFFF, 2, $urandom_range(0, 65535));
        @(negedge clk);
        source_bursty = 1'b0;
        sink_mode = SINK_RANDOM;
        for (int i = 0; i < 40; i++)
            pending_samples.push_back(pick_sample());
        hold_off_go = 1'b1;
        drain();

        // Delay beyond the ring length is clipped to it.
        configure(5, 18'h3FFFF, 65535);
        send_batch(40);

        // Zero gain: no echo at all.
        configure(16, 3, 0);
        send_batch(30);

        // A write to an unused index must not clear the stored taps.
        configure(16, 3, 50000);
        send_batch(15);
        cfg_put(REG_UNUSED, cfg_word_t'($urandom_range(0, 18'h3FFFF)));
        @(posedge clk);
        cfg_write <= 1'b0;
        send_batch(15);

        // Full ring at the memory depth with the longest delay.
        configure(RING_MAX, RING_MAX, 13107);
        send_batch(20);

        // Random settings.
        for (int k = 0; k < 9; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                ring = $urandom_range(1000, RING_MAX);
                dly = $urandom_range(1, 20);
            end
            else
            begin
                ring = $urandom_range(0, 40);
                dly = $urandom_range(0, ring + 3);
            end
            configure(ring, dly, $urandom_range(0, 65535));
            send_batch($urandom_range(10, 20));
            send_batch($urandom_range(10, 20));
        end

        // Let any stray output show up before the verdict.
        repeat (8) @(posedge clk);
        if (fault_count == 0 && echo_expected.size() == 0)
            $display("[feedback_echo_comb] OK");
        else
            $display("[feedback_echo_comb] ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("[feedback_echo_comb] ERROR");
        $finish;
    end

endmodule
